[rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/sgm_pkg.sv]
// Shared types and constants for the Sobel gradient magnitude block
package sgm_pkg;
   localparam int unsigned PixW = 24;
   localparam int unsigned RowW = 12;
   localparam int unsigned ColW = 11;
   localparam int unsigned RspW = 48;
   localparam logic [0:0] CsrWidth  = 1'b0;
   localparam logic [0:0] CsrHeight = 1'b1;
   typedef logic [PixW-1:0] pix_type;
   typedef struct packed {
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
      pix_type         pix;
   } rsp_type;
endpackage

[rtl/sgm_ram.sv]
// Generic single-port-write, registered-read RAM
module sgm_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

[rtl/sgm_isqrt.sv]
// Multi-cycle integer square root, one result bit per cycle, saturating
module sgm_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] sum,
   output logic        done,
   output logic [7:0]  root
);
   logic [16:0] s_ff;
   logic [7:0]  r_ff, bit_ff;
   logic        busy_ff;
   logic [7:0]  t;
   logic [15:0] tsq;
   assign t   = r_ff | bit_ff;
   assign tsq = t * t;
   assign done = busy_ff && bit_ff == 8'd1;
   assign root = (s_ff[16]) ? 8'hFF : ((tsq <= s_ff[15:0]) ? t : r_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
      if (start) begin
         s_ff <= sum; r_ff <= '0; bit_ff <= 8'h80;
      end else if (busy_ff) begin
         if (tsq <= s_ff[15:0]) r_ff <= t;
         bit_ff <= bit_ff >> 1;
      end
   end
endmodule

[rtl/sobel_gradient_magnitude.sv]
// Sobel gradient magnitude: line stores, 3x3 window, per-channel root
// A request is taken only in SIdle, so a new pixel waits until the last one is through SDone;
// each pixel passes SRead, then SCalc and SRoot (interior), SEmitI, SEmitB (border), SDone,
// results wait for rsp_tready, and an interior pixel runs one 8-step root per channel.
// Line stores are addressed with the incoming column at the request edge.
// Reset: synchronous, active high; clears counters, window and control.
module sobel_gradient_magnitude #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // in_chan0, in_chan1, in_chan2
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_row, out_col, out_chan0..2, pad 1'b0
   output logic        rsp_tlast   // last_of_run
);
   import sgm_pkg::*;
   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned MaxW = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
   localparam logic [3:0] SIdle = 4'd0, SRead = 4'd1, SCalc = 4'd2, SRoot = 4'd3,
      SEmitI = 4'd4, SEmitB = 4'd5, SDone = 4'd6;

   logic [3:0]  st_ff;
   logic [11:0] wreg_ff;
   logic [12:0] hreg_ff;
   logic [RowW-1:0] row_ff, r_ff;
   logic [ColW:0]   col_ff, c_ff;
   pix_type win_ff [6];
   pix_type pix_ff;
   logic [1:0]  k_ff;
   logic [16:0] sum_ff [3];
   logic [7:0]  mag_ff [3];
   logic        border_ff;
   logic [12:0] w_eff, h_eff;
   pix_type top, mid;
   logic        sq_start, sq_done;
   logic [7:0]  sq_root;
   logic [16:0] sq_sum;
   logic [AW-1:0] addr;

   assign w_eff = (wreg_ff < 12'd3) ? 13'd3 :
                  ({1'b0, wreg_ff} > 13'(MaxW)) ? 13'(MaxW) : {1'b0, wreg_ff};
   assign h_eff = (hreg_ff < 13'd3) ? 13'd3 : (hreg_ff > 13'd4096) ? 13'd4096 : hreg_ff;
   // Take register writes only between requests; they go ahead of a waiting request
   assign csr_ready = (st_ff == SIdle);
   assign req_tready = (st_ff == SIdle) && !csr_valid;
   assign addr = AW'(c_ff);

   // Wrap counters as seen by the incoming pixel
   logic [ColW:0]   cw;
   logic [RowW:0]   rw;
   always_comb begin
      cw = col_ff;
      rw = {1'b0, row_ff};
      if ({1'b0, col_ff} >= w_eff) begin
         cw = '0; rw = rw + 1'b1;
      end
      if (rw >= h_eff) rw = '0;
   end

   // Read the incoming column while idle so the data is ready in SRead
   logic [AW-1:0] rd_addr;
   assign rd_addr = (st_ff == SIdle) ? AW'(cw) : addr;

   logic in_range;
   assign in_range = {2'b0, c_ff} < 14'(MAX_WIDTH);
   logic we;
   assign we = (st_ff == SDone) && in_range;
   sgm_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_up (
      .clock, .we, .waddr(addr), .wdata(mid), .raddr(rd_addr), .rdata(top));
   pix_type mid_raw;
   sgm_ram #(.WIDTH(PixW), .DEPTH(MAX_WIDTH)) u_mid (
      .clock, .we, .waddr(addr), .wdata(pix_ff), .raddr(rd_addr), .rdata(mid_raw));
   assign mid = mid_raw;
   pix_type top_v, mid_v;
   assign top_v = in_range ? top : '0;
   assign mid_v = in_range ? mid_raw : '0;

   // Sobel sums for one channel
   function automatic logic [16:0] sob(input logic [7:0] a00, a01, a02, a10,
                                       a12, a20, a21, a22);
      logic signed [11:0] gx, gy;
      logic [21:0] s;
      gx = $signed({4'b0, a02}) + $signed({3'b0, a12, 1'b0}) + $signed({4'b0, a22})
         - $signed({4'b0, a00}) - $signed({3'b0, a10, 1'b0}) - $signed({4'b0, a20});
      gy = $signed({4'b0, a20}) + $signed({3'b0, a21, 1'b0}) + $signed({4'b0, a22})
         - $signed({4'b0, a00}) - $signed({3'b0, a01, 1'b0}) - $signed({4'b0, a02});
      s = 22'(gx * gx) + 22'(gy * gy);
      return (s >= 22'd65536) ? 17'h10000 : 17'(s);
   endfunction

   assign sq_start = (st_ff == SCalc) || (st_ff == SRoot && sq_done && k_ff != 2'd2);
   assign sq_sum = (st_ff == SCalc) ? sum_ff[0] : sum_ff[k_ff + 2'd1];
   sgm_isqrt u_sqrt (.clock, .reset, .start(sq_start), .sum(sq_sum),
                     .done(sq_done), .root(sq_root));

   logic interior;
   assign interior = (r_ff >= 12'd2) && (c_ff >= 12'd2);
   logic border;
   assign border = r_ff == 12'd0 || {1'b0, r_ff} == h_eff - 1'b1 ||
                   c_ff == '0 || {1'b0, c_ff} == w_eff - 1'b1;

   rsp_type rsp;
   always_comb begin
      if (st_ff == SEmitI) begin
         rsp.row = r_ff - 1'b1; rsp.col = ColW'(c_ff - 1'b1);
         rsp.pix = {mag_ff[2], mag_ff[1], mag_ff[0]};
      end else begin
         rsp.row = r_ff; rsp.col = ColW'(c_ff); rsp.pix = pix_ff;
      end
   end
   assign rsp_tvalid = (st_ff == SEmitI) || (st_ff == SEmitB);
   assign rsp_tdata = {1'b0, rsp.pix, rsp.col, rsp.row};
   assign rsp_tlast = (st_ff == SEmitB) || !border_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SIdle; wreg_ff <= 12'd640; hreg_ff <= 13'd480;
         row_ff <= '0; col_ff <= '0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrWidth) wreg_ff <= csr_data[11:0];
            else hreg_ff <= csr_data;
         end
         unique case (st_ff)
            SIdle: if (req_tvalid && req_tready) begin
               pix_ff <= req_tdata; r_ff <= rw[RowW-1:0]; c_ff <= cw; st_ff <= SRead;
            end
            SRead: begin
               border_ff <= border;
               // Skip straight to the update for a pixel with no result
               st_ff <= interior ? SCalc : (border ? SEmitB : SDone);
               for (int k = 0; k < 3; k++)
                  sum_ff[k] <= sob(win_ff[0][8*k+:8], win_ff[3][8*k+:8], top_v[8*k+:8],
                     win_ff[1][8*k+:8], mid_v[8*k+:8], win_ff[2][8*k+:8],
                     win_ff[5][8*k+:8], pix_ff[8*k+:8]);
               k_ff <= '0;
            end
            SCalc: st_ff <= SRoot;
            SRoot: if (sq_done) begin
               mag_ff[k_ff] <= sq_root;
               if (k_ff == 2'd2) st_ff <= SEmitI;
               k_ff <= k_ff + 1'b1;
            end
            SEmitI: if (rsp_tready) st_ff <= border_ff ? SEmitB : SDone;
            SEmitB: if (rsp_tready) st_ff <= SDone;
            SDone: begin
               win_ff[0] <= win_ff[3]; win_ff[1] <= win_ff[4]; win_ff[2] <= win_ff[5];
               win_ff[3] <= top_v; win_ff[4] <= mid_v; win_ff[5] <= pix_ff;
               if ({1'b0, c_ff} + 13'd1 >= w_eff) begin
                  col_ff <= '0;
                  row_ff <= ({1'b0, r_ff} + 13'd1 >= h_eff) ? '0 : r_ff + 1'b1;
               end else begin
                  col_ff <= c_ff + 1'b1; row_ff <= r_ff;
               end
               st_ff <= SIdle;
            end
            default: st_ff <= SIdle;
         endcase
      end
   end
endmodule

[rtl/sgm_checker.sv]
// Port-level checker for the Sobel block, bound to the top level
`include "assert_macros.svh"
module sgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   `CHK_IMPL(a_busy, clock, reset, rsp_tvalid, !req_tready, "request taken while result pending")
   `CHK_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `CHK_IMPL(a_pad, clock, reset, rsp_tvalid, !rsp_tdata[47], "pad bit set")
   `CHK_NEXT(a_noreq, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted twice")
endmodule
bind sobel_gradient_magnitude sgm_checker u_chk (.*);
